### rtl/dxp_pkg.sv
// ============================================================================
// dxp_pkg: shared types and constants for the disparity to XYZ point block
// Holds the fixed widths, register map, view codes, controller states and
// the command and status bundles between the controller and the datapath.
// ============================================================================
package dxp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int CNT_W   = 12;   // column and row counters
    localparam int DIM_W   = 13;   // image width and height
    localparam int DISP_W  = 16;   // disparity, Q12.4
    localparam int BASE_W  = 24;   // baseline, Q8.16
    localparam int OFS_W   = 24;   // camera offsets, Q8.16
    localparam int FOC_W   = 16;   // focal scale, Q4.12
    localparam int ZQ_W    = 40;   // depth before saturation
    localparam int NUM_W   = 54;   // widest dividend
    localparam int DEN_W   = 16;   // widest divisor
    localparam int MAG_W   = 14;   // magnitude of 2j-W or H-2i
    localparam int TMAG_W  = 41;   // clamped tx or ty magnitude
    localparam int SUM_W   = 56;   // offset sums and negations
    localparam int PT_W    = 32;   // output coordinates, Q16.16
    localparam int STEP_W  = 6;    // iteration counter
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MAG_W - 1);

    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_BASELINE = 3'd2,
        REG_FOCAL    = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Z = 3'd5,
        REG_MIN_DISP = 3'd6,
        REG_VIEW     = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        VIEW_FRONT = 2'd0,
        VIEW_RIGHT = 2'd1,
        VIEW_BACK  = 2'd2,
        VIEW_LEFT  = 2'd3
    } view_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_Z,
        ST_MUL_X,
        ST_DIV_X,
        ST_DIV_FX,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_DIV_FY,
        ST_FINISH
    } state_t;

    // Operand selection for the shared multiply/divide unit.
    typedef enum logic [2:0] {
        SEL_Z,
        SEL_MX,
        SEL_DX,
        SEL_FX,
        SEL_MY,
        SEL_DY,
        SEL_FY
    } sel_t;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [BASE_W-1:0] stereo_baseline;
        logic [FOC_W-1:0]  focal_scale;
        logic [OFS_W-1:0]  cam_offset_x;
        logic [OFS_W-1:0]  cam_offset_z;
        logic [DISP_W-1:0] min_disparity;
        logic [1:0]        view_direction;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic run;
        sel_t sel;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic in_pix_ok;
        logic unit_done;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/dxp_if.sv
// ============================================================================
// dxp_if: stream channels of the disparity to XYZ point block
// Pixel input channel and point output channel with valid/ready handshake.
// ============================================================================
interface dxp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] disparity_value;
    logic        frame_start;

    modport source (output valid, disparity_value, frame_start, input ready);
    modport sink   (input valid, disparity_value, frame_start, output ready);
endinterface

interface dxp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_valid;
    logic               frame_end;

    modport source (output valid, point_x, point_y, point_z, point_valid, frame_end,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_valid, frame_end,
                    output ready);
endinterface

### rtl/disparity_to_xyz_point_top.sv
// ============================================================================
// disparity_to_xyz_point_top: stereo disparity to 3D point converter
// Turns raster-order disparity pixels into saturated Q16.16 world points.
// ============================================================================
// Sequence: after its transfer, a valid pixel runs through five 54-step
// divisions and two 14-step multiplies on one shared unit, each loaded and
// then handed back to the controller, then a finish state; an invalid pixel
// goes straight to the finish state. Throughput: one pixel at a time; a
// point still waiting on the output holds the finish.
// Reset (rst_n, asynchronous): counters cleared, registers to their defaults.
module disparity_to_xyz_point_top
    import dxp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dxp_in_if.sink            in_ch,
    dxp_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    dxp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dxp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dxp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .disparity_value (in_ch.disparity_value),
        .frame_start     (in_ch.frame_start),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .point_x         (out_ch.point_x),
        .point_y         (out_ch.point_y),
        .point_z         (out_ch.point_z),
        .point_valid     (out_ch.point_valid),
        .frame_end       (out_ch.frame_end)
    );

endmodule

### rtl/dxp_regs.sv
// ============================================================================
// dxp_regs: configuration register file
// APB-style slave holding the camera and image settings.
// ============================================================================
module dxp_regs
    import dxp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_WIDTH:    cfg_next.image_width     = pwdata[DIM_W-1:0];
                REG_HEIGHT:   cfg_next.image_height    = pwdata[DIM_W-1:0];
                REG_BASELINE: cfg_next.stereo_baseline = pwdata[BASE_W-1:0];
                REG_FOCAL:    cfg_next.focal_scale     = pwdata[FOC_W-1:0];
                REG_OFFSET_X: cfg_next.cam_offset_x    = pwdata[OFS_W-1:0];
                REG_OFFSET_Z: cfg_next.cam_offset_z    = pwdata[OFS_W-1:0];
                REG_MIN_DISP: cfg_next.min_disparity   = pwdata[DISP_W-1:0];
                REG_VIEW:     cfg_next.view_direction  = pwdata[1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WIDTH:    prdata = DATA_W'(cfg_reg.image_width);
            REG_HEIGHT:   prdata = DATA_W'(cfg_reg.image_height);
            REG_BASELINE: prdata = DATA_W'(cfg_reg.stereo_baseline);
            REG_FOCAL:    prdata = DATA_W'(cfg_reg.focal_scale);
            REG_OFFSET_X: prdata = DATA_W'(cfg_reg.cam_offset_x);
            REG_OFFSET_Z: prdata = DATA_W'(cfg_reg.cam_offset_z);
            REG_MIN_DISP: prdata = DATA_W'(cfg_reg.min_disparity);
            REG_VIEW:     prdata = DATA_W'(cfg_reg.view_direction);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= DIM_W'(640);
            cfg_reg.image_height    <= DIM_W'(480);
            cfg_reg.stereo_baseline <= BASE_W'(65536);
            cfg_reg.focal_scale     <= FOC_W'(4096);
            cfg_reg.cam_offset_x    <= '0;
            cfg_reg.cam_offset_z    <= '0;
            cfg_reg.min_disparity   <= DISP_W'(16);
            cfg_reg.view_direction  <= VIEW_FRONT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/dxp_ctrl.sv
// ============================================================================
// dxp_ctrl: sequencing controller
// Walks one pixel through depth, X and Y operations on the shared unit.
// ============================================================================
module dxp_ctrl
    import dxp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.in_pix_ok ? ST_DIV_Z : ST_FINISH;
            end
            ST_DIV_Z:  if (status.unit_done) state_next = ST_MUL_X;
            ST_MUL_X:  if (status.unit_done) state_next = ST_DIV_X;
            ST_DIV_X:  if (status.unit_done) state_next = ST_DIV_FX;
            ST_DIV_FX: if (status.unit_done) state_next = ST_MUL_Y;
            ST_MUL_Y:  if (status.unit_done) state_next = ST_DIV_Y;
            ST_DIV_Y:  if (status.unit_done) state_next = ST_DIV_FY;
            ST_DIV_FY: if (status.unit_done) state_next = ST_FINISH;
            ST_FINISH: if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.run     = 1'b0;
        cmd.sel     = SEL_Z;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DIV_Z:  begin cmd.run = 1'b1; cmd.sel = SEL_Z;  end
            ST_MUL_X:  begin cmd.run = 1'b1; cmd.sel = SEL_MX; end
            ST_DIV_X:  begin cmd.run = 1'b1; cmd.sel = SEL_DX; end
            ST_DIV_FX: begin cmd.run = 1'b1; cmd.sel = SEL_FX; end
            ST_MUL_Y:  begin cmd.run = 1'b1; cmd.sel = SEL_MY; end
            ST_DIV_Y:  begin cmd.run = 1'b1; cmd.sel = SEL_DY; end
            ST_DIV_FY: begin cmd.run = 1'b1; cmd.sel = SEL_FY; end
            ST_FINISH: cmd.finish = status.out_free;
            default:   cmd.finish = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/dxp_dp.sv
// ============================================================================
// dxp_dp: pixel datapath
// Pixel counters, a shared bit-serial multiply/restoring divide unit, and
// the offset, rotation and saturation stage feeding the output register.
// ============================================================================
module dxp_dp
    import dxp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic [DISP_W-1:0]   disparity_value,
    input  logic                frame_start,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [PT_W-1:0] point_x,
    output logic signed [PT_W-1:0] point_y,
    output logic signed [PT_W-1:0] point_z,
    output logic                point_valid,
    output logic                frame_end
);

    localparam logic [DIM_W-1:0] MAX_W_C = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_C = DIM_W'(MAX_HEIGHT);
    localparam logic [NUM_W-1:0] LIM40   = NUM_W'(64'd1 << 40);

    // Effective configuration
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [FOC_W-1:0] f_eff;

    always_comb
    begin
        priority if (cfg.image_width == '0) w_eff = DIM_W'(1);
        else if (cfg.image_width > MAX_W_C) w_eff = MAX_W_C;
        else w_eff = cfg.image_width;
        priority if (cfg.image_height == '0) h_eff = DIM_W'(1);
        else if (cfg.image_height > MAX_H_C) h_eff = MAX_H_C;
        else h_eff = cfg.image_height;
        f_eff = (cfg.focal_scale == '0) ? FOC_W'(1) : cfg.focal_scale;
    end

    // Pixel capture and counters
    logic [CNT_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic [CNT_W-1:0]  col_cur, row_cur;
    logic              pix_ok;
    logic              col_wrap, row_wrap;
    logic [DISP_W-1:0] disp_reg;
    logic              valid_reg, fend_reg;
    logic [ZQ_W-1:0]   numz_reg;
    logic signed [MAG_W:0] dx_reg, dy_reg;

    assign col_cur  = frame_start ? '0 : col_reg;
    assign row_cur  = frame_start ? '0 : row_reg;
    assign pix_ok   = (disparity_value != '0) && (disparity_value >= cfg.min_disparity);
    assign col_wrap = {1'b0, col_cur} >= (w_eff - DIM_W'(1));
    assign row_wrap = {1'b0, row_cur} >= (h_eff - DIM_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.capture)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_cur + CNT_W'(1);
            end
            else
            begin
                col_next = col_cur + CNT_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            disp_reg  <= disparity_value;
            valid_reg <= pix_ok;
            fend_reg  <= col_wrap && row_wrap;
            numz_reg  <= {ZQ_W'(w_eff) * ZQ_W'(cfg.stereo_baseline)} << 3;
            dx_reg    <= $signed({2'b00, col_cur, 1'b0}) - $signed({2'b00, w_eff});
            dy_reg    <= $signed({2'b00, h_eff}) - $signed({2'b00, row_cur, 1'b0});
        end
    end

    // Shared multiply/divide unit
    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic              is_div_reg;
    sel_t              sel_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  quo_reg, acc_reg, mcand_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [MAG_W-1:0]  mplier_reg;
    logic              sign_reg;
    logic              load;
    logic              last;
    logic [DEN_W:0]    rem_sh;
    logic              qbit;
    logic [DEN_W-1:0]  rem_step;
    logic [NUM_W-1:0]  quo_step, acc_step;
    logic [NUM_W-1:0]  ld_num;
    logic [DEN_W-1:0]  ld_den;
    logic signed [MAG_W:0] ld_diff;
    logic [MAG_W-1:0]  ld_mag;

    logic [ZQ_W-1:0]        zq_reg;
    logic [NUM_W-1:0]       prod_reg;
    logic [TMAG_W-1:0]      tmag_reg;
    logic signed [NUM_W-1:0] xq_reg, yq_reg;

    assign load = cmd.run && !active_reg && !done_reg;
    assign last = active_reg && (cnt_reg == (is_div_reg ? DIV_LAST : MUL_LAST));

    assign rem_sh   = {rem_reg, quo_reg[NUM_W-1]};
    assign qbit     = rem_sh >= {1'b0, den_reg};
    assign rem_step = qbit ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
    assign quo_step = {quo_reg[NUM_W-2:0], qbit};
    assign acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    always_comb
    begin
        ld_diff = (cmd.sel == SEL_MX) ? dx_reg : dy_reg;
        ld_mag  = ld_diff[MAG_W] ? MAG_W'(-ld_diff) : ld_diff[MAG_W-1:0];
        ld_num  = '0;
        ld_den  = DEN_W'(1);
        unique case (cmd.sel)
            SEL_Z:
            begin
                ld_num = NUM_W'(numz_reg);
                ld_den = disp_reg;
            end
            SEL_DX:
            begin
                ld_num = prod_reg;
                ld_den = DEN_W'({w_eff, 1'b0});
            end
            SEL_DY:
            begin
                ld_num = prod_reg;
                ld_den = DEN_W'({h_eff, 1'b0});
            end
            SEL_FX, SEL_FY:
            begin
                ld_num = NUM_W'({tmag_reg, 12'b0});
                ld_den = f_eff;
            end
            default:
            begin
                ld_num = '0;
                ld_den = DEN_W'(1);
            end
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        if (load)
            active_next = 1'b1;
        else if (last)
        begin
            active_next = 1'b0;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sel_reg    <= cmd.sel;
            is_div_reg <= !(cmd.sel == SEL_MX || cmd.sel == SEL_MY);
            cnt_reg    <= '0;
            quo_reg    <= ld_num;
            rem_reg    <= '0;
            den_reg    <= ld_den;
            acc_reg    <= '0;
            mcand_reg  <= NUM_W'(zq_reg);
            mplier_reg <= ld_mag;
            if (cmd.sel == SEL_MX || cmd.sel == SEL_MY)
                sign_reg <= ld_diff[MAG_W];
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg + STEP_W'(1);
            if (is_div_reg)
            begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
            end
            else
            begin
                acc_reg    <= acc_step;
                mcand_reg  <= {mcand_reg[NUM_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MAG_W-1:1]};
            end
            if (last)
            begin
                unique case (sel_reg)
                    SEL_Z:          zq_reg   <= quo_step[ZQ_W-1:0];
                    SEL_MX, SEL_MY: prod_reg <= acc_step;
                    SEL_DX, SEL_DY: tmag_reg <= (quo_step > LIM40) ?
                                                TMAG_W'(LIM40) : quo_step[TMAG_W-1:0];
                    SEL_FX:         xq_reg   <= sign_reg ? -$signed(quo_step)
                                                         : $signed(quo_step);
                    SEL_FY:         yq_reg   <= sign_reg ? -$signed(quo_step)
                                                         : $signed(quo_step);
                    default:        zq_reg   <= zq_reg;
                endcase
            end
        end
    end

    // Offsets, view rotation, saturation
    function automatic logic signed [PT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = -SUM_W'(64'sh8000_0000);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[PT_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] x_sum, y_sum, z_sum;
    logic signed [SUM_W-1:0] rx, ry, rz;
    logic                    out_valid_reg;
    logic signed [PT_W-1:0]  px_reg, py_reg, pz_reg;
    logic                    pv_reg, fe_reg;

    always_comb
    begin
        x_sum = SUM_W'(xq_reg) + SUM_W'($signed(cfg.cam_offset_x));
        y_sum = SUM_W'(yq_reg);
        z_sum = $signed({{(SUM_W-ZQ_W){1'b0}}, zq_reg}) + SUM_W'($signed(cfg.cam_offset_z));
        unique case (view_t'(cfg.view_direction))
            VIEW_FRONT: begin rx = x_sum;  rz = z_sum;  end
            VIEW_RIGHT: begin rx = z_sum;  rz = -x_sum; end
            VIEW_BACK:  begin rx = -x_sum; rz = -z_sum; end
            VIEW_LEFT:  begin rx = -z_sum; rz = x_sum;  end
        endcase
        ry = y_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            px_reg <= valid_reg ? sat32(rx) : '0;
            py_reg <= valid_reg ? sat32(ry) : '0;
            pz_reg <= valid_reg ? sat32(rz) : '0;
            pv_reg <= valid_reg;
            fe_reg <= fend_reg;
        end
    end

    assign status.in_pix_ok = pix_ok;
    assign status.unit_done = done_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_z     = pz_reg;
    assign point_valid = pv_reg;
    assign frame_end   = fe_reg;

endmodule

### rtl/dxp_checker.sv
// ============================================================================
// dxp_checker: port-level checks for the point converter
// Watches the channel and configuration ports of the top level.
// ============================================================================
module dxp_checker
    import dxp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic [31:0] point_z,
    input logic        point_valid,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pixel accepted while previous one in flight");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
        else $error("invalid pixel with nonzero point");

    a_no_out_while_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid) || !point_valid)
        else $error("valid point appeared too soon after a transfer");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind disparity_to_xyz_point_top dxp_checker u_dxp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .point_x     (out_ch.point_x),
    .point_y     (out_ch.point_y),
    .point_z     (out_ch.point_z),
    .point_valid (out_ch.point_valid),
    .pready      (pready)
);
